>>> rtl/core/tdmm_pkg.sv
// ----------------------------------------------------------------------------
// tdmm_pkg: shared definitions for the table-driven Mealy machine
// Table geometry, field widths, item action codes, configuration register
// indexes, the table entry layout and the controller state type.
// ----------------------------------------------------------------------------
package tdmm_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 64;
  localparam int ACTION_BITS = 4;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Field widths fixed by the interface.
  localparam int STATE_W = 8;
  localparam int EVENT_W = 8;
  localparam int AID_W   = 4;
  localparam int PARAM_W = 32;
  localparam int COUNT_W = 7;
  localparam int CFG_W   = 8;

  // Reset values of the configuration registers.
  localparam logic [COUNT_W-1:0] ENTRY_COUNT_RST   = COUNT_W'(1);
  localparam logic [STATE_W-1:0] INITIAL_STATE_RST = '0;
  localparam logic [STATE_W-1:0] FINAL_STATE_RST   = '1;

  // Table depth expressed at the width of the entry count register.
  localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(TABLE_DEPTH);

  // Item action codes.
  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_EVENT   = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_ENTRY_COUNT   = 2'd0,
    CFG_INITIAL_STATE = 2'd1,
    CFG_FINAL_STATE   = 2'd2,
    CFG_FINAL_NOTIFY  = 2'd3
  } cfg_index_t;

  // One transition table entry.
  typedef struct packed {
    logic [STATE_W-1:0]     st;
    logic [EVENT_W-1:0]     ev;
    logic [STATE_W-1:0]     nx;
    logic [ACTION_BITS-1:0] act;
  } entry_t;

  // Controller states.
  typedef enum logic {
    S_IDLE,
    S_SCAN
  } ctrl_state_t;

endpackage

>>> rtl/core/table_driven_mealy_machine.sv
// ----------------------------------------------------------------------------
// table_driven_mealy_machine: programmable Mealy state machine
// A transition table in a synchronous memory is written by items and
// searched first-match by event items, one entry per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Items are issued with start while busy is low; the transaction takes
//   place at that clock edge. Each item yields exactly one result, shown on
//   the result ports for one cycle with done high. The receiver cannot stall,
//   so results must be taken in the cycle they appear.
//   Table writes, restarts and unused action codes finish without a scan: done
//   rises in the cycle after the item, and busy never rises for them.
//   An event item in the final state, or with an entry count of zero, also
//   finishes without a scan. Otherwise the table scan reads one entry per cycle
//   through the single memory read port; each entry is compared from the
//   registered read data, and the scan ends at the first match or after
//   min(entry_count, 64) entries. The next item may be issued in the
//   cycle in which done is high.
//   Configuration writes use cfg_valid, cfg_ready, cfg_index and cfg_data;
//   cfg_ready is always high. The user writes only while no item is pending;
//   the block does not enforce this. Reset restores the register defaults and
//   the initial state. Table content is undefined after reset until written.
// ----------------------------------------------------------------------------
module table_driven_mealy_machine (
  input  logic                             clk,
  input  logic                             rst,
  // Item channel.
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       action,
  input  logic [tdmm_pkg::IDX_W-1:0]       entry_index,
  input  logic [tdmm_pkg::STATE_W-1:0]     entry_state,
  input  logic [tdmm_pkg::EVENT_W-1:0]     entry_event,
  input  logic [tdmm_pkg::STATE_W-1:0]     entry_next,
  input  logic [tdmm_pkg::AID_W-1:0]       entry_action_id,
  input  logic [tdmm_pkg::EVENT_W-1:0]     event_code,
  input  logic [tdmm_pkg::PARAM_W-1:0]     event_parameter,
  // Result channel.
  output logic                             done,
  output logic                             transitioned,
  output logic [tdmm_pkg::STATE_W-1:0]     from_state,
  output logic [tdmm_pkg::STATE_W-1:0]     to_state,
  output logic [tdmm_pkg::EVENT_W-1:0]     fired_event,
  output logic [tdmm_pkg::AID_W-1:0]       fired_action,
  output logic [tdmm_pkg::PARAM_W-1:0]     fired_parameter,
  output logic                             reached_final,
  output logic [tdmm_pkg::STATE_W-1:0]     state_now,
  // Configuration channel.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [tdmm_pkg::CFG_W-1:0]       cfg_data
);

  import tdmm_pkg::*;

  // Configuration registers.
  logic [COUNT_W-1:0] entry_count;
  logic [STATE_W-1:0] initial_state;
  logic [STATE_W-1:0] final_state;
  logic               final_notify_enable;

  // Machine state and the latched event item.
  ctrl_state_t        state, state_next;
  logic [STATE_W-1:0] cur, cur_next;
  logic [EVENT_W-1:0] ev_q;
  logic [PARAM_W-1:0] par_q;

  // Scan pipeline.
  logic [COUNT_W-1:0] cnt, cnt_next;
  logic               rd_ok, rd_ok_next;
  logic               rd_last, rd_last_next;
  logic               rd_en;
  entry_t             rd_data;

  // Transition table memory.
  entry_t             mem [TABLE_DEPTH];
  logic               mem_we;

  // Control decisions.
  logic [COUNT_W-1:0] limit;
  logic               skip_scan;
  logic               match;
  logic               fin;
  logic               hit;
  logic               load_item;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);

  // Number of entries searched, clipped to the table depth.
  assign limit     = (entry_count > DEPTH_CNT) ? DEPTH_CNT : entry_count;
  assign skip_scan = (cur == final_state) || (limit == '0);
  assign match     = (rd_data.st == cur) && (rd_data.ev == ev_q);

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count         <= ENTRY_COUNT_RST;
      initial_state       <= INITIAL_STATE_RST;
      final_state         <= FINAL_STATE_RST;
      final_notify_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_ENTRY_COUNT:   entry_count         <= cfg_data[COUNT_W-1:0];
        CFG_INITIAL_STATE: initial_state       <= cfg_data[STATE_W-1:0];
        CFG_FINAL_STATE:   final_state         <= cfg_data[STATE_W-1:0];
        CFG_FINAL_NOTIFY:  final_notify_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Next controller state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start && (action_t'(action) == ACT_EVENT) && !skip_scan) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (fin) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Controller outputs: memory access, scan issue and result capture.
  always_comb begin
    fin          = 1'b0;
    hit          = 1'b0;
    cur_next     = cur;
    mem_we       = 1'b0;
    rd_en        = 1'b0;
    load_item    = 1'b0;
    cnt_next     = cnt;
    rd_ok_next   = 1'b0;
    rd_last_next = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          load_item = 1'b1;
          cnt_next  = '0;
          case (action_t'(action))
            ACT_WRITE: begin
              mem_we = (32'(entry_index) < TABLE_DEPTH);
              fin    = 1'b1;
            end
            ACT_EVENT: begin
              fin = skip_scan;
            end
            ACT_RESTART: begin
              cur_next = initial_state;
              fin      = 1'b1;
            end
            default: fin = 1'b1;
          endcase
        end
      end
      S_SCAN: begin
        // Issue the next read while entries remain.
        if (cnt < limit) begin
          rd_en        = 1'b1;
          cnt_next     = cnt + COUNT_W'(1);
          rd_ok_next   = 1'b1;
          rd_last_next = (cnt == limit - COUNT_W'(1));
        end
        // Check the entry read in the previous cycle.
        if (rd_ok) begin
          if (match) begin
            hit      = 1'b1;
            fin      = 1'b1;
            cur_next = rd_data.nx;
          end else if (rd_last) begin
            fin = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cur     <= INITIAL_STATE_RST;
      cnt     <= '0;
      rd_ok   <= 1'b0;
      rd_last <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      cur     <= cur_next;
      cnt     <= cnt_next;
      rd_ok   <= rd_ok_next;
      rd_last <= rd_last_next;
      done    <= fin;
    end
  end

  // Latched event code and parameter of the item in progress.
  always_ff @(posedge clk) begin
    if (load_item) begin
      ev_q  <= event_code;
      par_q <= event_parameter;
    end
  end

  // Table memory write port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[entry_index] <= '{st:  entry_state,
                            ev:  entry_event,
                            nx:  entry_next,
                            act: ACTION_BITS'(entry_action_id)};
    end
  end

  // Table memory read port with registered data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[cnt[IDX_W-1:0]];
    end
  end

  // Result registers, loaded when an item completes.
  always_ff @(posedge clk) begin
    if (fin) begin
      transitioned    <= hit;
      from_state      <= cur;
      to_state        <= hit ? rd_data.nx : '0;
      fired_event     <= hit ? ev_q : '0;
      fired_action    <= hit ? AID_W'(rd_data.act) : '0;
      fired_parameter <= hit ? par_q : '0;
      reached_final   <= hit && (rd_data.nx == final_state) && final_notify_enable;
      state_now       <= cur_next;
    end
  end

endmodule
